### rtl/core/fbp_pkg.sv
package fbp_pkg;

   localparam int NUM_TAPS        = 43;
   localparam int HALF_TAPS       = (NUM_TAPS + 1) / 2;
   localparam int SAMPLE_W        = 10;
   localparam int PAIR_W          = SAMPLE_W + 1;
   localparam int COEFF_FRAC_BITS = 15;
   localparam int COEFF_W         = COEFF_FRAC_BITS + 1;
   localparam int PROD_W          = COEFF_W + PAIR_W + 1;
   localparam int OUT_W           = 27;
   localparam int MILLION         = 1000000;
   localparam int GROUP_SIZE      = 6;
   localparam int NUM_GROUPS      = (HALF_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef logic        [SAMPLE_W-1:0] sample_type;
   typedef logic signed [OUT_W-1:0]    acc_type;
   typedef logic signed [COEFF_W-1:0]  coeff_type;

   typedef coeff_type  coeff_array_type [HALF_TAPS];
   typedef sample_type tap_array_type   [NUM_TAPS];
   typedef acc_type    prod_array_type  [HALF_TAPS];
   typedef acc_type    group_array_type [NUM_GROUPS];

   // bandpass taps in millionths, tap 0 up to the centre tap; the rest mirror
   localparam int HALF_COEFF_MICRO [HALF_TAPS] = '{
      678, 504, -1055, 0, 2536, 0, -5715, 0, 10381, 0, -16616,
      0, 25228, 0, -38748, 0, 65030, 0, -176141, 0, 360000, 500000
   };

   // round to nearest, ties away from zero
   function automatic coeff_array_type quantize_coeffs();
      coeff_array_type c;
      longint          m;
      longint          mag;
      longint          q;
      for (int i = 0; i < HALF_TAPS; i++) begin
         m    = longint'(HALF_COEFF_MICRO[i]);
         mag  = (m < 0) ? -m : m;
         q    = (mag * (longint'(1) << COEFF_FRAC_BITS) + MILLION / 2) / MILLION;
         c[i] = coeff_type'((m < 0) ? -q : q);
      end
      return c;
   endfunction

   localparam coeff_array_type COEFFS = quantize_coeffs();

endpackage

### rtl/core/fbp_delay_line.sv
module fbp_delay_line (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  fbp_pkg::sample_type   sample,
   output fbp_pkg::tap_array_type taps
);

   fbp_pkg::sample_type delay_ff [fbp_pkg::NUM_TAPS-1];
   fbp_pkg::sample_type delay_in [fbp_pkg::NUM_TAPS-1];

   always_comb begin
      delay_in[0] = sample;
      for (int k = 1; k < fbp_pkg::NUM_TAPS - 1; k++) begin
         delay_in[k] = delay_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < fbp_pkg::NUM_TAPS - 1; k++) begin
            delay_ff[k] <= '0;
         end
      end else if (shift_en) begin
         delay_ff <= delay_in;
      end
   end

   // tap 0 is the word being accepted, the rest come from the line
   always_comb begin
      taps[0] = sample;
      for (int k = 1; k < fbp_pkg::NUM_TAPS; k++) begin
         taps[k] = delay_ff[k-1];
      end
   end

endmodule

### rtl/core/fbp_tap_products.sv
module fbp_tap_products (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  fbp_pkg::tap_array_type  taps,
   output logic                    out_valid,
   input  logic                    out_ready,
   output fbp_pkg::prod_array_type prods
);

   logic                    valid_ff;
   logic                    valid_in;
   fbp_pkg::prod_array_type prod_ff;
   fbp_pkg::prod_array_type prod_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // symmetric taps: pre-add the mirrored pair, then one constant multiply
   always_comb begin
      logic        [fbp_pkg::PAIR_W-1:0] pair;
      logic signed [fbp_pkg::PROD_W-1:0] full;
      for (int i = 0; i < fbp_pkg::HALF_TAPS; i++) begin
         if (i == fbp_pkg::NUM_TAPS - 1 - i) begin
            pair = {1'b0, taps[i]};
         end else begin
            pair = {1'b0, taps[i]} + {1'b0, taps[fbp_pkg::NUM_TAPS-1-i]};
         end
         full       = fbp_pkg::COEFFS[i] * $signed({1'b0, pair});
         prod_in[i] = fbp_pkg::acc_type'(full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prods     = prod_ff;

   a_prod_hold : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(prod_ff[0]))
      else $error("product stage dropped a held word");

endmodule

### rtl/core/fbp_sum_tree.sv
module fbp_sum_tree (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  fbp_pkg::prod_array_type prods,
   output logic                    out_valid,
   input  logic                    out_stall,
   output fbp_pkg::acc_type        result
);

   logic                     group_valid_ff;
   logic                     group_valid_in;
   fbp_pkg::group_array_type group_ff;
   fbp_pkg::group_array_type group_in;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   fbp_pkg::acc_type         result_ff;
   fbp_pkg::acc_type         result_in;
   logic                     out_ready;

   // sums wrap modulo 2^27; the exact total fits, so nothing is lost
   always_comb begin
      for (int g = 0; g < fbp_pkg::NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < fbp_pkg::GROUP_SIZE; j++) begin
            if (g * fbp_pkg::GROUP_SIZE + j < fbp_pkg::HALF_TAPS) begin
               group_in[g] = group_in[g] + prods[g * fbp_pkg::GROUP_SIZE + j];
            end
         end
      end
   end

   always_comb begin
      result_in = '0;
      for (int g = 0; g < fbp_pkg::NUM_GROUPS; g++) begin
         result_in = result_in + group_ff[g];
      end
   end

   assign out_ready      = !out_valid_ff || !out_stall;
   assign in_ready       = !group_valid_ff || out_ready;
   assign group_valid_in = in_ready ? in_valid : group_valid_ff;
   assign out_valid_in   = out_ready ? group_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         group_valid_ff <= group_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         group_ff <= group_in;
      end
      if (out_ready) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

   a_group_hold : assert property (@(posedge clock) disable iff (reset)
      group_valid_ff && !out_ready |=> group_valid_ff)
      else $error("partial sum word lost while output stalled");

   a_out_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff)
      else $error("result word valid straight after reset");

endmodule

### rtl/core/fir_bandpass_43_tap_core.sv
// 43-tap symmetric bandpass FIR, fixed Q1.15 coefficients.
// Input channel req_: one unsigned 10-bit converter sample per word,
// taken at a rising edge with req_valid high and req_stall low.
// Result channel rsp_: one signed 27-bit filtered value per sample,
// 15 fractional bits, handed over with rsp_valid high and rsp_stall low.
// Throughput: one word per cycle while rsp_stall is low. Three register
// stages (pre-add and constant multiply, partial sums, final sum) lie
// between an accepted sample and its result on rsp_.
// Every stage advances when the stage after it is empty or moving, so
// bubbles close up; a stalled receiver holds rsp_ and backs up the
// pipeline, raising req_stall only once all three stages are full.
// Reset (synchronous, active high) clears the 42-sample delay line to
// zero and empties the pipeline.
module fir_bandpass_43_tap_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fbp_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [fbp_pkg::OUT_W-1:0] rsp_filtered
);

   fbp_pkg::tap_array_type  taps;
   fbp_pkg::prod_array_type prods;
   logic                    prod_ready;
   logic                    prod_valid;
   logic                    sum_ready;
   logic                    accept;

   assign req_stall = !prod_ready;
   assign accept    = req_valid && prod_ready;

   fbp_delay_line u_delay_line (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .sample   (req_sample),
      .taps     (taps)
   );

   fbp_tap_products u_tap_products (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (prod_ready),
      .taps      (taps),
      .out_valid (prod_valid),
      .out_ready (sum_ready),
      .prods     (prods)
   );

   fbp_sum_tree u_sum_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (sum_ready),
      .prods     (prods),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .result    (rsp_filtered)
   );

   a_line_shift : assert property (@(posedge clock) disable iff (reset)
      accept |=> taps[1] == $past(req_sample))
      else $error("accepted word not at head of delay line");

endmodule

### dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 200000;
   localparam int QUIET_TAIL  = 200;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 64;
   localparam int DRAIN_WAIT  = 8;

   // bandpass taps in millionths, tap 0 up to the centre; the others mirror these
   localparam int TAP_MICRO [fbp_pkg::HALF_TAPS] = '{
      678, 504, -1055, 0, 2536, 0, -5715, 0, 10381, 0, -16616,
      0, 25228, 0, -38748, 0, 65030, 0, -176141, 0, 360000, 500000
   };

   typedef struct packed {
      fbp_pkg::sample_type sample;
      logic                known;
      fbp_pkg::acc_type    val;
   } stim_word_type;

   // impulse after reset gives the first taps times full scale
   localparam stim_word_type DIRECTED [20] = '{
      '{10'd0,    1'b1, 27'sd0},
      '{10'd1023, 1'b1, 27'sd22506},
      '{10'd0,    1'b1, 27'sd17391},
      '{10'd0,    1'b1, -27'sd35805},
      '{10'd0,    1'b1, 27'sd0},
      '{10'd0,    1'b1, 27'sd84909},
      '{10'd1023, 1'b0, 27'sd0},
      '{10'd1023, 1'b0, 27'sd0},
      '{10'd1023, 1'b0, 27'sd0},
      '{10'd1,    1'b0, 27'sd0},
      '{10'd2,    1'b0, 27'sd0},
      '{10'h155,  1'b0, 27'sd0},
      '{10'h2AA,  1'b0, 27'sd0},
      '{10'd512,  1'b0, 27'sd0},
      '{10'd511,  1'b0, 27'sd0},
      '{10'h3FE,  1'b0, 27'sd0},
      '{10'd0,    1'b0, 27'sd0},
      '{10'd1023, 1'b0, 27'sd0},
      '{10'd0,    1'b0, 27'sd0},
      '{10'd1023, 1'b0, 27'sd0}
   };

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [fbp_pkg::SAMPLE_W-1:0]     req_sample;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [fbp_pkg::OUT_W-1:0] rsp_filtered;

   stim_word_type       stim [$];
   fbp_pkg::acc_type    filtered_due [$];
   fbp_pkg::acc_type    oldest_due;
   fbp_pkg::sample_type history [fbp_pkg::NUM_TAPS-1];
   int                  stim_total;
   int                  words_sent;
   int                  errors;
   int                  cycle_count;

   fir_bandpass_43_tap_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered)
   );

   function automatic longint tap_weight(int k);
      int     mirror;
      longint micro;
      longint mag;
      longint q;
      mirror = (k < fbp_pkg::HALF_TAPS) ? k : fbp_pkg::NUM_TAPS - 1 - k;
      micro  = TAP_MICRO[mirror];
      mag    = (micro < 0) ? -micro : micro;
      q      = (mag * (longint'(1) << fbp_pkg::COEFF_FRAC_BITS) + 500000) / 1000000;
      return (micro < 0) ? -q : q;
   endfunction

   // one sample through the filter: sum over the taps, then shift the history
   function automatic fbp_pkg::acc_type step_filter(fbp_pkg::sample_type x);
      longint sum;
      sum = tap_weight(0) * longint'(x);
      for (int k = 1; k < fbp_pkg::NUM_TAPS; k++)
         sum += tap_weight(k) * longint'(history[k-1]);
      for (int k = fbp_pkg::NUM_TAPS - 2; k > 0; k--)
         history[k] = history[k-1];
      history[0] = x;
      return fbp_pkg::acc_type'(sum[fbp_pkg::OUT_W-1:0]);
   endfunction

   function automatic void queue_sample(fbp_pkg::sample_type s);
      stim.push_back('{sample: s, known: 1'b0, val: '0});
   endfunction

   function automatic bit idling_on(int done);
      return (done + QUIET_TAIL < stim_total) && ((done / 160) % 5 != 4);
   endfunction

   task automatic build_stimulus();
      int                  run_len;
      int                  level;
      int                  slope;
      fbp_pkg::sample_type s;
      foreach (DIRECTED[i])
         stim.push_back(DIRECTED[i]);
      while (stim.size() < ITEM_TARGET) begin
         run_len = $urandom_range(8, 60);
         case ($urandom_range(0, 9))
            5: begin
               for (int i = 0; i < run_len; i++) begin
                  case ($urandom_range(0, 5))
                     0: s = 10'd0;
                     1: s = 10'd1;
                     2: s = 10'd511;
                     3: s = 10'd512;
                     4: s = 10'd1022;
                     default: s = 10'd1023;
                  endcase
                  queue_sample(s);
               end
            end
            // full scale on every positive tap: largest output
            6: for (int j = 0; j < fbp_pkg::NUM_TAPS; j++)
                  queue_sample((tap_weight(j) > 0) ? 10'd1023 : 10'd0);
            // full scale on every negative tap: most negative output
            7: for (int j = 0; j < fbp_pkg::NUM_TAPS; j++)
                  queue_sample((tap_weight(j) < 0) ? 10'd1023 : 10'd0);
            8: begin
               level = $urandom_range(0, 1023);
               slope = $urandom_range(0, 64) - 32;
               for (int i = 0; i < run_len; i++) begin
                  queue_sample(fbp_pkg::sample_type'(level));
                  level += slope;
               end
            end
            9: begin
               s = fbp_pkg::sample_type'($urandom_range(0, 1023));
               for (int i = 0; i < run_len; i++)
                  queue_sample(s);
            end
            default: for (int i = 0; i < run_len; i++)
                        queue_sample(fbp_pkg::sample_type'($urandom_range(0, 1023)));
         endcase
      end
      stim_total = stim.size();
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // receiver: short random stalls, one long hold-off to back the pipe up
   initial begin
      int  stall_left;
      bit  held_long;
      rsp_stall  = 1'b0;
      stall_left = 0;
      held_long  = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!held_long && words_sent >= HOLD_AT) begin
            held_long  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (idling_on(words_sent) && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_due.size() == 0) begin
            $error("rsp_filtered: expected nothing, actual %0d", rsp_filtered);
            errors++;
         end else begin
            oldest_due = filtered_due.pop_front();
            if (rsp_filtered !== oldest_due) begin
               $error("rsp_filtered: expected %0d, actual %0d", oldest_due, rsp_filtered);
               errors++;
            end
         end
      end
   end

   initial begin
      int               gap_left;
      stim_word_type    w;
      fbp_pkg::acc_type predicted;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      words_sent  = 0;
      errors      = 0;
      cycle_count = 0;
      gap_left    = 0;
      foreach (history[i])
         history[i] = '0;
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (words_sent < stim_total) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            w         = stim[words_sent];
            predicted = step_filter(w.sample);
            filtered_due.push_back(w.known ? w.val : predicted);
            words_sent++;
         end
         // a stalled word stays put; otherwise pick the next one or a gap
         if (!req_valid || !req_stall) begin
            if (words_sent == stim_total) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idling_on(words_sent) && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               req_valid  <= 1'b1;
               req_sample <= stim[words_sent].sample;
            end
         end
      end

      while (filtered_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
